### rtl/rme_pkg.sv
package rme_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NST   = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int SQ_ST = 16;            // sqrt root is SQ_ST+1 bits (value <= 2^16)
    localparam int AW    = 34;            // Q2.30 angle accumulator width
    localparam int CW    = 40;            // CORDIC x/y datapath width

    localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [15:0]   HALF_PI_Q12 = 16'sd6434;
    localparam logic signed [15:0]   PI_Q12      = 16'sd12868;
    localparam logic signed [15:0]   Y_HIGH_Q12  = 16'sd19302;
    localparam logic signed [16:0]   ONE_Q14     = 17'sd16384;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_NEG  = 2'd1,
        LOCK_POS  = 2'd2
    } t_lock;

    // one lane of vectoring CORDIC state
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } t_lane;

    function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sh3243F6A8;
            5'd1:  atan_q30 = 34'sh1DAC6705;
            5'd2:  atan_q30 = 34'sh0FADBAFC;
            5'd3:  atan_q30 = 34'sh07F56EA6;
            5'd4:  atan_q30 = 34'sh03FEAB76;
            5'd5:  atan_q30 = 34'sh01FFD55B;
            5'd6:  atan_q30 = 34'sh00FFFAAA;
            5'd7:  atan_q30 = 34'sh007FFF55;
            5'd8:  atan_q30 = 34'sh003FFFEA;
            5'd9:  atan_q30 = 34'sh001FFFFD;
            5'd10: atan_q30 = 34'sh000FFFFF;
            5'd11: atan_q30 = 34'sh0007FFFF;
            5'd12: atan_q30 = 34'sh0003FFFF;
            5'd13: atan_q30 = 34'sh0001FFFF;
            5'd14: atan_q30 = 34'sh0000FFFF;
            5'd15: atan_q30 = 34'sh00007FFF;
            5'd16: atan_q30 = 34'sh00003FFF;
            5'd17: atan_q30 = 34'sh00001FFF;
            5'd18: atan_q30 = 34'sh00000FFF;
            5'd19: atan_q30 = 34'sh000007FF;
            5'd20: atan_q30 = 34'sh000003FF;
            5'd21: atan_q30 = 34'sh000001FF;
            5'd22: atan_q30 = 34'sh000000FF;
            5'd23: atan_q30 = 34'sh0000007F;
            default: atan_q30 = '0;
        endcase
    endfunction

    // lane set-up: quadrant fold, base angle, scale by 2^16
    function automatic t_lane lane_init(input logic signed [17:0] y,
                                        input logic signed [17:0] x);
        t_lane l;
        logic signed [17:0] xx;
        logic signed [17:0] yy;
        l.ang = '0;
        xx = x;
        yy = y;
        if (x < 0) begin
            l.ang = (y >= 0) ? PI_Q30 : -PI_Q30;
            xx = -xx;
            yy = -yy;
        end
        l.x = CW'(xx) <<< 16;
        l.y = CW'(yy) <<< 16;
        return l;
    endfunction

    // Q2.30 to Q3.12 with rounding and saturation
    function automatic logic signed [15:0] to_q12(input logic signed [AW-1:0] v,
                                                  input logic signed [15:0] hi);
        logic signed [AW:0] s;
        logic signed [AW:0] r;
        s = (AW+1)'(v) + (AW+1)'(131072);
        r = s >>> 18;
        if (r < -(AW+1)'(12868))     to_q12 = -PI_Q12;
        else if (r > (AW+1)'(hi))    to_q12 = hi;
        else                         to_q12 = 16'(r);
    endfunction

endpackage

### rtl/rme_cell.sv
// One CORDIC micro-rotation over all five lanes plus pipeline side data.
module rme_cell (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [4:0]            i_idx,
    input  rme_pkg::t_lane [4:0]  i_lane,
    input  logic [4:0]            i_zero,
    input  logic [1:0]            i_code,
    output rme_pkg::t_lane [4:0]  o_lane,
    output logic [4:0]            o_zero,
    output logic [1:0]            o_code
);
    rme_pkg::t_lane [4:0] n_lane;
    rme_pkg::t_lane [4:0] r_lane;
    logic [4:0]           r_zero;
    logic [1:0]           r_code;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            if (i_lane[k].y >= 0) begin
                n_lane[k].x   = i_lane[k].x + (i_lane[k].y >>> i_idx);
                n_lane[k].y   = i_lane[k].y - (i_lane[k].x >>> i_idx);
                n_lane[k].ang = i_lane[k].ang + rme_pkg::atan_q30(i_idx);
            end else begin
                n_lane[k].x   = i_lane[k].x - (i_lane[k].y >>> i_idx);
                n_lane[k].y   = i_lane[k].y + (i_lane[k].x >>> i_idx);
                n_lane[k].ang = i_lane[k].ang - rme_pkg::atan_q30(i_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_zero <= i_zero;
            r_code <= i_code;
        end
    end

    assign o_lane = r_lane;
    assign o_zero = r_zero;
    assign o_code = r_code;
endmodule

### rtl/rme_sqrt_cell.sv
// One restoring square-root step; carries the matrix terms alongside.
module rme_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [33:0]       i_rem,
    input  logic [33:0]       i_root,
    input  logic [33:0]       i_bit,
    input  logic [111:0]      i_side,
    output logic [33:0]       o_rem,
    output logic [33:0]       o_root,
    output logic [33:0]       o_bit,
    output logic [111:0]      o_side
);
    logic [33:0]  r_rem, r_root, r_bit, n_rem, n_root;
    logic [111:0] r_side;

    always_comb begin
        if (i_rem >= i_root + i_bit) begin
            n_rem  = i_rem - (i_root + i_bit);
            n_root = (i_root >> 1) + i_bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_bit  <= i_bit >> 2;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_bit  = r_bit;
    assign o_side = r_side;
endmodule

### rtl/rotation_matrix_to_euler_top.sv
// Pipeline: input register, 17 square-root cells, lane set-up register,
// NST CORDIC cells (CORDIC_STAGES capped at 24) and the output register.
// Throughput: one item per cycle; the whole chain advances when the output
// register is free or being taken, so stalls freeze every stage together.
// Reset (synchronous, i_rst_n low) clears the valid bits and sets
// lock_tolerance to 16; data registers are not reset.
module rotation_matrix_to_euler_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [14:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_row0_x,
    input  logic signed [15:0] i_row0_y,
    input  logic signed [15:0] i_row0_z,
    input  logic signed [15:0] i_row1_x,
    input  logic signed [15:0] i_row1_z,
    input  logic signed [15:0] i_row2_x,
    input  logic signed [15:0] i_row2_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_angle_x,
    output logic signed [15:0] o_angle_y,
    output logic signed [14:0] o_angle_z,
    output logic [1:0]         o_lock_case
);
    localparam int NS  = rme_pkg::NST;
    localparam int SQN = rme_pkg::SQ_ST + 2;   // 17 sqrt steps plus input reg
    localparam int LAT = SQN + 1 + NS + 1;     // valid pipe length

    logic [14:0]    r_tol;
    logic [LAT-1:0] r_vld;
    logic           adv;

    // whole pipe moves only when the output slot frees up
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= 15'd16;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_tol <= i_cfg_wdata;
            if (adv) r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[LAT-1];

    // ---- stage 0: lock detect, saturate, s*s ----
    logic signed [16:0] s0, d_neg, d_pos;
    logic [16:0]        a_neg, a_pos;
    logic [1:0]         code0;
    always_comb begin
        d_neg = 17'(i_row0_z) + rme_pkg::ONE_Q14;
        d_pos = 17'(i_row0_z) - rme_pkg::ONE_Q14;
        a_neg = d_neg[16] ? 17'(-d_neg) : 17'(d_neg);
        a_pos = d_pos[16] ? 17'(-d_pos) : 17'(d_pos);
        if (a_neg < 17'(r_tol))      code0 = rme_pkg::LOCK_NEG;
        else if (a_pos < 17'(r_tol)) code0 = rme_pkg::LOCK_POS;
        else                         code0 = rme_pkg::LOCK_NONE;
        s0 = 17'(i_row0_z);
        if (s0 > rme_pkg::ONE_Q14)  s0 = rme_pkg::ONE_Q14;
        if (s0 < -rme_pkg::ONE_Q14) s0 = -rme_pkg::ONE_Q14;
    end

    logic [33:0]  r_rad;
    logic [111:0] r_side0;   // {code,s,pad,m00,m01,m10,m12,m20} packed below; m22 is carried separately
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rad   <= 34'((34'sd268435456 - 34'(s0) * 34'(s0)) * 34'sd16);
            r_side0 <= {code0, s0[16:0], 13'd0, i_row0_x, i_row0_y, i_row1_x,
                        i_row1_z, i_row2_x};
        end
    end
    logic signed [15:0] r_m22_0;
    always_ff @(posedge i_clk) if (adv) r_m22_0 <= i_row2_z;

    // ---- square root chain ----
    logic [33:0]  rem  [SQN];
    logic [33:0]  root [SQN];
    logic [33:0]  bitv [SQN];
    logic [111:0] side [SQN];
    logic signed [15:0] m22p [SQN];
    assign rem[0]  = r_rad;
    assign root[0] = '0;
    assign bitv[0] = 34'h1 << 32;
    assign side[0] = r_side0;
    assign m22p[0] = r_m22_0;

    for (genvar g = 0; g < SQN - 1; g++) begin : g_sq
        rme_sqrt_cell u_sq (
            .i_clk (i_clk), .i_en (adv),
            .i_rem (rem[g]), .i_root (root[g]), .i_bit (bitv[g]),
            .i_side (side[g]),
            .o_rem (rem[g+1]), .o_root (root[g+1]), .o_bit (bitv[g+1]),
            .o_side (side[g+1])
        );
        always_ff @(posedge i_clk) if (adv) m22p[g+1] <= m22p[g];
    end

    // ---- lane set-up ----
    logic [1:0]         cd;
    logic signed [16:0] ss;
    logic signed [15:0] m00, m01, m10, m12, m20, m22;
    logic signed [17:0] c18;
    rme_pkg::t_lane [4:0] lane0;
    logic [4:0]           zero0;
    always_comb begin
        {cd, ss} = side[SQN-1][111:93];
        m00 = side[SQN-1][79:64];
        m01 = side[SQN-1][63:48];
        m10 = side[SQN-1][47:32];
        m12 = side[SQN-1][31:16];
        m20 = side[SQN-1][15:0];
        m22 = m22p[SQN-1];
        c18 = 18'(root[SQN-1]);
        // lane 0: asin; 1,2: x pair; 3,4: z pair (lock uses lane 3)
        lane0[0] = rme_pkg::lane_init(18'(ss) <<< 2, c18);
        lane0[1] = rme_pkg::lane_init(18'(m12), 18'(m22));
        lane0[2] = rme_pkg::lane_init(-18'(m12), -18'(m22));
        if (cd == rme_pkg::LOCK_NEG) begin
            lane0[3] = rme_pkg::lane_init(18'(m10), 18'(m20));
        end else if (cd == rme_pkg::LOCK_POS) begin
            lane0[3] = rme_pkg::lane_init(-18'(m10), -18'(m20));
        end else begin
            lane0[3] = rme_pkg::lane_init(18'(m01), 18'(m00));
        end
        lane0[4] = rme_pkg::lane_init(-18'(m01), -18'(m00));
        zero0[0] = (ss == 0) && (c18 == 0);
        zero0[1] = (m12 == 0) && (m22 == 0);
        zero0[2] = zero0[1];
        zero0[3] = (cd == rme_pkg::LOCK_NONE) ? ((m01 == 0) && (m00 == 0))
                                              : ((m10 == 0) && (m20 == 0));
        zero0[4] = (m01 == 0) && (m00 == 0);
    end

    rme_pkg::t_lane [4:0] r_lane0;
    logic [4:0]           r_zero0;
    logic [1:0]           r_code0;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lane0 <= lane0;
            r_zero0 <= zero0;
            r_code0 <= cd;
        end
    end

    // ---- CORDIC chain ----
    rme_pkg::t_lane [4:0] lanes [NS+1];
    logic [4:0]           zs    [NS+1];
    logic [1:0]           cs    [NS+1];
    assign lanes[0] = r_lane0;
    assign zs[0]    = r_zero0;
    assign cs[0]    = r_code0;
    for (genvar g = 0; g < NS; g++) begin : g_cc
        rme_cell u_cell (
            .i_clk (i_clk), .i_en (adv), .i_idx (5'(g)),
            .i_lane (lanes[g]), .i_zero (zs[g]), .i_code (cs[g]),
            .o_lane (lanes[g+1]), .o_zero (zs[g+1]), .o_code (cs[g+1])
        );
    end

    // ---- final selection ----
    logic signed [33:0] a [5];
    logic signed [15:0] ya, yb, x1, x2, z1, z2;
    logic [17:0]        s1, s2;
    logic signed [15:0] n_ax, n_ay, n_az;
    always_comb begin
        for (int k = 0; k < 5; k++)
            a[k] = zs[NS][k] ? '0 : lanes[NS][k].ang;
        ya = rme_pkg::to_q12(-a[0], rme_pkg::Y_HIGH_Q12);
        yb = rme_pkg::to_q12(rme_pkg::PI_Q30 + a[0], rme_pkg::Y_HIGH_Q12);
        x1 = rme_pkg::to_q12(a[1], rme_pkg::PI_Q12);
        x2 = rme_pkg::to_q12(a[2], rme_pkg::PI_Q12);
        z1 = rme_pkg::to_q12(a[3], rme_pkg::PI_Q12);
        z2 = rme_pkg::to_q12(a[4], rme_pkg::PI_Q12);
        s1 = 18'(x1[15] ? -x1 : x1) + 18'(ya[15] ? -ya : ya) + 18'(z1[15] ? -z1 : z1);
        s2 = 18'(x2[15] ? -x2 : x2) + 18'(yb[15] ? -yb : yb) + 18'(z2[15] ? -z2 : z2);
        if (cs[NS] == rme_pkg::LOCK_NEG) begin
            n_ax = '0; n_ay = rme_pkg::HALF_PI_Q12; n_az = z1;
        end else if (cs[NS] == rme_pkg::LOCK_POS) begin
            n_ax = '0; n_ay = -rme_pkg::HALF_PI_Q12; n_az = z1;
        end else if (s1 <= s2) begin
            n_ax = x1; n_ay = ya; n_az = z1;
        end else begin
            n_ax = x2; n_ay = yb; n_az = z2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_angle_x   <= n_ax[14:0];
            o_angle_y   <= n_ay;
            o_angle_z   <= n_az[14:0];
            o_lock_case <= cs[NS];
        end
    end

    a_lock_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lock_case == rme_pkg::LOCK_NEG |-> o_angle_y == rme_pkg::HALF_PI_Q12)
        else $error("lock y");
    a_lock_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_lock_case != rme_pkg::LOCK_NONE |-> o_angle_x == 0)
        else $error("lock x");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle_y))
        else $error("hold");
endmodule

### tb/tb_rotation_matrix_to_euler_top.sv
`default_nettype none

module tb_rotation_matrix_to_euler_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Q2.30 arctangent table, atan(2^-i)
    localparam longint ATAN_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };
    localparam longint PI30   = 64'd3373259426;
    localparam int     LAT    = 20 + rme_pkg::NST;
    localparam int     N_RAND = 1500;

    typedef struct packed {
        logic signed [15:0] m00, m01, m02, m10, m12, m20, m22;
    } t_matrix;

    typedef struct packed {
        logic signed [14:0] ax;
        logic signed [15:0] ay;
        logic signed [14:0] az;
        rme_pkg::t_lock     lc;
    } t_euler;

    // directed row: matrix, whether the result is typed in, and that result
    typedef struct {
        t_matrix m;
        bit      fixed;
        t_euler  e;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_matrix in_m = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [14:0] o_ax, o_az;
    logic signed [15:0] o_ay;
    logic [1:0] o_lc;

    always #5 clk = ~clk;

    rotation_matrix_to_euler_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_row0_x(in_m.m00), .i_row0_y(in_m.m01), .i_row0_z(in_m.m02),
        .i_row1_x(in_m.m10), .i_row1_z(in_m.m12),
        .i_row2_x(in_m.m20), .i_row2_z(in_m.m22),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_angle_x(o_ax), .o_angle_y(o_ay), .o_angle_z(o_az),
        .o_lock_case(o_lc)
    );

    // ---------------------------------------------------------------
    // Angle predictor, own copy of the tolerance register
    // ---------------------------------------------------------------
    longint   tol_model = 16;
    t_euler   pending_angles[$];
    int       n_err = 0;

    // idling percentages, switched per phase
    int snd_idle = 0;
    int rcv_idle = 0;
    int hold_cycles = 0;   // long receiver hold-off when non-zero

    function automatic longint fshr(longint v, int k);
        return v >>> k;    // arithmetic shift is floor for signed values
    endfunction

    function automatic longint isqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring CORDIC arctangent, Q2.30
    function automatic longint arctan2(longint y, longint x);
        longint base, ang, dx, dy;
        base = 0;
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? PI30 : -PI30;
            x = -x;
            y = -y;
        end
        x *= 65536;
        y *= 65536;
        for (int i = 0; i < rme_pkg::CORDIC_STAGES && i < 24; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_TAB[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_TAB[i];
            end
        end
        return base + ang;
    endfunction

    function automatic longint q30_to_q12(longint v, longint hi);
        longint r;
        r = fshr(v + 131072, 18);
        if (r < -12868) r = -12868;
        if (r > hi) r = hi;
        return r;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_euler euler_of(t_matrix m);
        longint m00, m01, m02, m10, m12, m20, m22;
        longint s, c, y1, ya, yb, x1, x2, z1, z2;
        t_euler e;
        m00 = m.m00; m01 = m.m01; m02 = m.m02; m10 = m.m10;
        m12 = m.m12; m20 = m.m20; m22 = m.m22;
        if (absl(m02 + 16384) < tol_model) begin
            e.lc = rme_pkg::LOCK_NEG;
            e.ax = '0;
            e.ay = 16'sd6434;
            e.az = 15'(q30_to_q12(arctan2(m10, m20), 12868));
        end else if (absl(m02 - 16384) < tol_model) begin
            e.lc = rme_pkg::LOCK_POS;
            e.ax = '0;
            e.ay = -16'sd6434;
            e.az = 15'(q30_to_q12(arctan2(-m10, -m20), 12868));
        end else begin
            s = m02;
            if (s > 16384) s = 16384;
            if (s < -16384) s = -16384;
            c = isqrt(((64'd1 << 28) - s * s) * 16);
            y1 = -arctan2(s * 4, c);
            ya = q30_to_q12(y1, 19302);
            yb = q30_to_q12(PI30 - y1, 19302);
            x1 = q30_to_q12(arctan2(m12, m22), 12868);
            x2 = q30_to_q12(arctan2(-m12, -m22), 12868);
            z1 = q30_to_q12(arctan2(m01, m00), 12868);
            z2 = q30_to_q12(arctan2(-m01, -m00), 12868);
            e.lc = rme_pkg::LOCK_NONE;
            // smaller absolute sum wins, tie to the first solution
            if (absl(x1) + absl(ya) + absl(z1) <= absl(x2) + absl(yb) + absl(z2)) begin
                e.ax = 15'(x1); e.ay = 16'(ya); e.az = 15'(z1);
            end else begin
                e.ax = 15'(x2); e.ay = 16'(yb); e.az = 15'(z2);
            end
        end
        return e;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_err++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall, plus an optional long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        t_euler w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("unexpected item, lock_case", o_lc, -1);
            end else begin
                w = pending_angles.pop_front();
                if (o_ax !== w.ax) report_mismatch("angle_x", o_ax, w.ax);
                if (o_ay !== w.ay) report_mismatch("angle_y", o_ay, w.ay);
                if (o_az !== w.az) report_mismatch("angle_z", o_az, w.az);
                if (o_lc !== w.lc) report_mismatch("lock_case", o_lc, w.lc);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    t_row directed[$];

    // one item: optional random gap, then hold until accepted
    task automatic send_matrix(t_matrix m);
        while ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_m <= m;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_angles.push_back(euler_of(m));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0) @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [14:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_model = v;
    endtask

    function automatic logic signed [15:0] rnd_elem();
        case ($urandom_range(9))
            0: return 16'($urandom());                      // full 16-bit, out of range too
            1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            2: return 16'sd0;
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // random matrix terms, with row0_z often near the lock points
    function automatic t_matrix rnd_matrix();
        t_matrix m;
        m.m00 = rnd_elem(); m.m01 = rnd_elem(); m.m10 = rnd_elem();
        m.m12 = rnd_elem(); m.m20 = rnd_elem(); m.m22 = rnd_elem();
        case ($urandom_range(5))
            0: m.m02 = 16'($signed($urandom_range(80)) + 16344);
            1: m.m02 = 16'(-16424 + $signed($urandom_range(80)));
            default: m.m02 = rnd_elem();
        endcase
        return m;
    endfunction

    function automatic t_matrix mk(int a, int b, int c, int d, int e, int f, int g);
        t_matrix m;
        m.m00 = 16'(a); m.m01 = 16'(b); m.m02 = 16'(c); m.m10 = 16'(d);
        m.m12 = 16'(e); m.m20 = 16'(f); m.m22 = 16'(g);
        return m;
    endfunction

    function automatic t_euler ex(int ax, int ay, int az, rme_pkg::t_lock lc);
        t_euler e;
        e.ax = 15'(ax); e.ay = 16'(ay); e.az = 15'(az); e.lc = lc;
        return e;
    endfunction

    task automatic add_row(t_matrix m, bit fixed = 0, t_euler e = '0);
        t_row r;
        r.m = m; r.fixed = fixed; r.e = e;
        directed.push_back(r);
    endtask

    initial begin
        t_row r;
        t_euler got;
        // identity: all angles zero
        add_row(mk(16384, 0, 0, 0, 0, 0, 16384), 1, ex(0, 0, 0, rme_pkg::LOCK_NONE));
        // gimbal lock at -1, all zero column terms: z from atan2(0,0)
        add_row(mk(0, 0, -16384, 0, 0, 0, 0), 1, ex(0, 6434, 0, rme_pkg::LOCK_NEG));
        // gimbal lock at +1
        add_row(mk(0, 0, 16384, 0, 0, 0, 0), 1, ex(0, -6434, 0, rme_pkg::LOCK_POS));
        // lock, x fixed at zero even with non-zero row terms
        add_row(mk(5000, -7000, 16380, 9000, 12000, -3000, 4000));
        add_row(mk(-5000, 7000, -16370, -9000, -12000, 3000, -4000));
        // atan2 of zero y and negative x gives +pi
        add_row(mk(-16384, 0, 0, 0, 0, -16384, -16384));
        // row0_z out of range, saturated before asin
        add_row(mk(100, 200, 32767, 300, 400, 500, 600));
        add_row(mk(100, 200, -32768, 300, 400, 500, 600));
        // extremes of every field except row0_z
        add_row(mk(32767, 32767, 0, 32767, 32767, 32767, 32767));
        add_row(mk(-32768, -32768, 0, -32768, -32768, -32768, -32768));
        add_row(mk(-1, -1, -1, -1, -1, -1, -1));
        add_row(mk(16384, -16384, 8192, -16384, 16384, -16384, 16384));
        add_row(mk(0, 16384, -8192, 16384, 0, 16384, 0));
        // just outside the default tolerance
        add_row(mk(1000, 2000, 16368, 3000, 4000, 5000, 6000));
        add_row(mk(1000, 2000, -16368, 3000, 4000, 5000, 6000));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset tolerance
        foreach (directed[i]) begin
            r = directed[i];
            send_matrix(r.m);
            if (r.fixed) begin
                // the typed-in value must agree with the prediction just queued
                got = pending_angles[pending_angles.size() - 1];
                if (got !== r.e) report_mismatch("directed row", i, -1);
                pending_angles[pending_angles.size() - 1] = r.e;
            end
        end
        drain();

        // zero tolerance: cosine of zero without lock
        write_tolerance(15'd0);
        send_matrix(mk(1000, 2000, 16384, 3000, 4000, 5000, 6000));
        send_matrix(mk(1000, 2000, -16384, 3000, 4000, 5000, 6000));
        drain();
        // tolerance 16384: row0_z of 0 locks neither way, 8000 locks at +1
        write_tolerance(15'd16384);
        send_matrix(mk(1000, 2000, 0, 3000, 4000, 5000, 6000));
        send_matrix(mk(1000, 2000, 8000, -3000, 4000, -5000, 6000));
        drain();
        write_tolerance(15'h7FFF);
        send_matrix(rnd_matrix());
        drain();

        // random phases; phase 0: sender idles little, receiver a lot; phase 1 the reverse; phase 2 no idling
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 9 : (ph == 1) ? 55 : 0;
            rcv_idle = (ph == 0) ? 55 : (ph == 1) ? 9 : 0;
            write_tolerance(ph == 0 ? 15'd16 : ph == 1 ? 15'($urandom_range(400)) : 15'd64);
            // long hold-off so the pipe fills and stalls its input
            if (ph == 2) hold_cycles = 3 * LAT;
            for (int n = 0; n < N_RAND / 3; n++) begin
                send_matrix(rnd_matrix());
                // one pause per phase until everything is back
                if (n == 250) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pending_angles.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        if (n_err == 0)
            $display("tb_rotation_matrix_to_euler_top: done, clean");
        else
            $display("tb_rotation_matrix_to_euler_top: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("tb_rotation_matrix_to_euler_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/rme_pkg.sv
rtl/rme_cell.sv
rtl/rme_sqrt_cell.sv
rtl/rotation_matrix_to_euler_top.sv
tb/tb_rotation_matrix_to_euler_top.sv
